// File: rtl/core/plr_pkg.sv
// plr_pkg: shared types and constants of the polyphase linear resampler
// no dependencies; used by plr_ctrl, plr_datapath, the top level and the checker
package plr_pkg;

    localparam int STEP_W    = 22;
    localparam int ONE_Q16   = 65536;
    localparam int FRAC_W    = 16;
    localparam int TAP_W     = 16;
    localparam int TAP_IDX_W = 6;
    localparam int WEIGHT_W  = 17;
    localparam int OPB_W     = 18;

    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_TAP    = 1'b1
    } in_cmd_t;

    // command from controller to datapath, one per cycle
    typedef struct packed {
        logic issue;     // one multiply-accumulate op enters the pipe
        logic interp;    // op belongs to an interpolation, else to a branch
        logic first;     // first term of a sum
        logic last;      // last term of a sum
        logic src_hist;  // branch op uses the history line, else the new sample
        logic zero_tap;  // tap lies past the prototype filter
        logic out_last;  // final output of this sample
        logic v0_wr;     // copy previous top phase into slot 0
        logic load_x;    // capture the new sample
        logic tap_wr;    // write one tap
        logic clr;       // clearing pass write
        logic hist_wr;   // push the sample into the history line
    } dp_cmd_t;

    // datapath status
    typedef struct packed {
        logic busy;      // ops still in the pipe
        logic out_full;  // output register holds a result
    } dp_stat_t;

endpackage

// File: rtl/core/plr_ctrl.sv
// plr_ctrl: sequencer of the resampler (clearing pass, branch sums, interpolation)
// depends on plr_pkg; drives plr_datapath through dp_cmd_t and reads dp_stat_t
module plr_ctrl
    import plr_pkg::*;
#(
    parameter int NUM_PHASES = 8,
    parameter int NUM_TAPS   = 64,
    localparam int PL   = (NUM_TAPS + NUM_PHASES - 1) / NUM_PHASES,
    localparam int TW   = $clog2(NUM_TAPS),
    localparam int HLD  = (PL > 1) ? PL - 1 : 1,
    localparam int HW   = (HLD > 1) ? $clog2(HLD) : 1,
    localparam int VW   = $clog2(NUM_PHASES + 1),
    localparam int JW   = $clog2(NUM_PHASES),
    localparam int IW   = (PL > 1) ? $clog2(PL) : 1,
    localparam int TTW  = $clog2(PL * NUM_PHASES + 1),
    localparam int PPW  = FRAC_W + $clog2(NUM_PHASES) + 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                in_cmd,
    input  logic [STEP_W-1:0]   step_q,
    input  dp_stat_t            stat,
    output dp_cmd_t             dcmd,
    output logic [TW-1:0]       tap_addr,
    output logic [HW-1:0]       hist_addr,
    output logic [VW-1:0]       v_addr,
    output logic [TW-1:0]       clr_addr,
    output logic [WEIGHT_W-1:0] weight
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_START    = 9'b000000100,
        S_FIR      = 9'b000001000,
        S_FIR_WAIT = 9'b000010000,
        S_INT_A    = 9'b000100000,
        S_INT_B    = 9'b001000000,
        S_FINISH   = 9'b010000000,
        S_SPARE    = 9'b100000000
    } state_t;

    localparam logic signed [PPW-1:0] LIMIT = PPW'(NUM_PHASES * ONE_Q16);
    localparam logic signed [PPW-1:0] WRAP  = PPW'((NUM_PHASES + 1) * ONE_Q16);

    state_t                  state_reg, state_next;
    logic [TW-1:0]           clr_reg, clr_next;
    logic [JW-1:0]           j_reg, j_next;
    logic [IW-1:0]           i_reg, i_next;
    logic [TTW-1:0]          t_reg, t_next;
    logic [HW-1:0]           rp_reg, rp_next;
    logic [HW-1:0]           wp_reg, wp_next;
    logic signed [PPW-1:0]   p_reg, p_next;
    logic signed [PPW-1:0]   pt_reg, pt_next;
    logic [JW-1:0]           k_reg, k_next;
    logic [FRAC_W-1:0]       mu_reg, mu_next;
    logic signed [PPW-1:0]   st;
    logic [HW-1:0]           newest;
    logic                    accept;

    // effective step, at least one phase
    assign st = (step_q < STEP_W'(ONE_Q16)) ? PPW'(ONE_Q16) : $signed(PPW'(step_q));

    // most recent history slot
    assign newest = (wp_reg == '0) ? HW'(HLD - 1) : wp_reg - HW'(1);

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign clr_addr = clr_reg;

    // state and counter update
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        t_next     = t_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        p_next     = p_reg;
        pt_next    = pt_reg;
        k_next     = k_reg;
        mu_next    = mu_reg;
        dcmd       = '0;
        tap_addr   = TW'(t_reg);
        hist_addr  = rp_reg;
        v_addr     = VW'(j_reg) + VW'(1);
        weight     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                dcmd.clr = 1'b1;
                clr_next = clr_reg + TW'(1);
                if (clr_reg == TW'(NUM_TAPS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_TAP)
                    begin
                        dcmd.tap_wr = 1'b1;
                    end
                    else
                    begin
                        dcmd.load_x = 1'b1;
                        state_next  = S_START;
                    end
                end
            end
            S_START:
            begin
                dcmd.v0_wr = 1'b1;
                p_next     = pt_reg + PPW'(ONE_Q16);
                j_next     = '0;
                i_next     = '0;
                t_next     = '0;
                rp_next    = newest;
                state_next = S_FIR;
            end
            S_FIR:
            begin
                dcmd.issue    = 1'b1;
                dcmd.first    = (i_reg == '0);
                dcmd.last     = (i_reg == IW'(PL - 1));
                dcmd.src_hist = (i_reg != '0);
                dcmd.zero_tap = (t_reg >= TTW'(NUM_TAPS));
                if (i_reg == IW'(PL - 1))
                begin
                    i_next  = '0;
                    t_next  = TTW'(j_reg) + TTW'(1);
                    rp_next = newest;
                    j_next  = j_reg + JW'(1);
                    if (j_reg == JW'(NUM_PHASES - 1))
                    begin
                        state_next = S_FIR_WAIT;
                    end
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                    t_next = t_reg + TTW'(NUM_PHASES);
                    if (i_reg != '0)
                    begin
                        rp_next = (rp_reg == '0) ? HW'(HLD - 1) : rp_reg - HW'(1);
                    end
                end
            end
            S_FIR_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = S_INT_A;
                end
            end
            S_INT_A:
            begin
                k_next  = p_reg[FRAC_W +: JW];
                mu_next = p_reg[FRAC_W-1:0];
                v_addr  = VW'(p_reg[FRAC_W +: JW]);
                weight  = WEIGHT_W'(ONE_Q16) - {1'b0, p_reg[FRAC_W-1:0]};
                if (p_reg >= LIMIT)
                begin
                    state_next = S_FINISH;
                end
                else if (!stat.busy && !stat.out_full)
                begin
                    dcmd.issue  = 1'b1;
                    dcmd.interp = 1'b1;
                    dcmd.first  = 1'b1;
                    state_next  = S_INT_B;
                end
            end
            S_INT_B:
            begin
                v_addr        = VW'(k_reg) + VW'(1);
                weight        = {1'b0, mu_reg};
                dcmd.issue    = 1'b1;
                dcmd.interp   = 1'b1;
                dcmd.last     = 1'b1;
                dcmd.out_last = ((p_reg + st) >= LIMIT);
                p_next        = p_reg + st;
                state_next    = S_INT_A;
            end
            S_FINISH:
            begin
                pt_next = p_reg - WRAP;
                if (PL > 1)
                begin
                    dcmd.hist_wr = 1'b1;
                    hist_addr    = wp_reg;
                    wp_next      = (wp_reg == HW'(HLD - 1)) ? '0 : wp_reg + HW'(1);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            t_reg     <= '0;
            rp_reg    <= '0;
            wp_reg    <= '0;
            p_reg     <= '0;
            pt_reg    <= '0;
            k_reg     <= '0;
            mu_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            t_reg     <= t_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            p_reg     <= p_next;
            pt_reg    <= pt_next;
            k_reg     <= k_next;
            mu_reg    <= mu_next;
        end
    end

endmodule

// File: rtl/core/plr_datapath.sv
// plr_datapath: tap store, history line, phase value store, shared MAC and output register
// depends on plr_pkg; commanded by plr_ctrl
module plr_datapath
    import plr_pkg::*;
#(
    parameter int NUM_PHASES   = 8,
    parameter int NUM_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16,
    localparam int PL    = (NUM_TAPS + NUM_PHASES - 1) / NUM_PHASES,
    localparam int TW    = $clog2(NUM_TAPS),
    localparam int HLD   = (PL > 1) ? PL - 1 : 1,
    localparam int HW    = (HLD > 1) ? $clog2(HLD) : 1,
    localparam int VW    = $clog2(NUM_PHASES + 1),
    localparam int PW    = SAMPLE_WIDTH + OPB_W,
    localparam int ACC_W = PW + $clog2(PL + 1) + 2
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dp_cmd_t                        dcmd,
    input  logic [TW-1:0]                  tap_addr,
    input  logic [HW-1:0]                  hist_addr,
    input  logic [VW-1:0]                  v_addr,
    input  logic [TW-1:0]                  clr_addr,
    input  logic [WEIGHT_W-1:0]            weight,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [TAP_IDX_W-1:0]           tap_index,
    input  logic signed [TAP_W-1:0]        tap_value,
    output dp_stat_t                       stat,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           last
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    logic signed [TAP_W-1:0]        tap_mem [NUM_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_mem [HLD];
    logic signed [SAMPLE_WIDTH-1:0] v_mem [NUM_PHASES + 1];

    logic signed [TAP_W-1:0]        tap_q;
    logic signed [SAMPLE_WIDTH-1:0] hist_q;
    logic signed [SAMPLE_WIDTH-1:0] v_q;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_top_reg;

    // stage 1: memory read
    logic                s1_valid_reg;
    logic                s1_interp, s1_first, s1_last, s1_src_hist, s1_zero, s1_out_last;
    logic [VW-1:0]       s1_vaddr;
    logic [WEIGHT_W-1:0] s1_weight;
    // stage 2: product
    logic                s2_valid_reg;
    logic                s2_interp, s2_first, s2_last, s2_out_last;
    logic [VW-1:0]       s2_vaddr;
    logic signed [PW-1:0] prod_reg;
    // stage 3: accumulate
    logic                done_reg;
    logic                s3_interp, s3_out_last;
    logic [VW-1:0]       s3_vaddr;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic signed [SAMPLE_WIDTH-1:0] opa;
    logic signed [OPB_W-1:0]        opb;
    logic signed [ACC_W-1:0]        shifted;
    logic signed [SAMPLE_WIDTH-1:0] result;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;
    logic                           out_last_reg;

    // tap store: clearing pass or tap write, read registered
    always_ff @(posedge clk)
    begin
        if (dcmd.clr)
        begin
            tap_mem[clr_addr] <= '0;
        end
        else if (dcmd.tap_wr && (int'(tap_index) < NUM_TAPS))
        begin
            tap_mem[TW'(tap_index)] <= tap_value;
        end
        tap_q <= tap_mem[tap_addr];
    end

    // history line as a circular buffer
    always_ff @(posedge clk)
    begin
        if (dcmd.clr && (int'(clr_addr) < HLD))
        begin
            hist_mem[HW'(clr_addr)] <= '0;
        end
        else if (dcmd.hist_wr)
        begin
            hist_mem[hist_addr] <= x_reg;
        end
        hist_q <= hist_mem[hist_addr];
    end

    // phase value store: slot 0 is the previous top phase
    always_ff @(posedge clk)
    begin
        if (dcmd.v0_wr)
        begin
            v_mem[0] <= prev_top_reg;
        end
        else if (done_reg && !s3_interp)
        begin
            v_mem[s3_vaddr] <= result;
        end
        v_q <= v_mem[v_addr];
    end

    // sample capture and previous top phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_top_reg <= '0;
        end
        else if (done_reg && !s3_interp && (s3_vaddr == VW'(NUM_PHASES)))
        begin
            prev_top_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.load_x)
        begin
            x_reg <= sample_in;
        end
    end

    // operand select and product
    assign opa = s1_interp ? v_q : (s1_src_hist ? hist_q : x_reg);
    assign opb = s1_interp ? $signed({1'b0, s1_weight}) :
                 (s1_zero ? '0 : OPB_W'(tap_q));

    // accumulate with rounding offset loaded on the first term
    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            if (s2_first)
            begin
                acc_next = (s2_interp ? ACC_W'(1 << 15) : ACC_W'(1 << 14)) + ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // floor shift and saturation
    assign shifted = s3_interp ? (acc_reg >>> FRAC_W) : (acc_reg >>> 15);
    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            result = SAMPLE_WIDTH'(SAT_MAX);
        end
        else if (shifted < SAT_MIN)
        begin
            result = SAMPLE_WIDTH'(SAT_MIN);
        end
        else
        begin
            result = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_interp   <= dcmd.interp;
        s1_first    <= dcmd.first;
        s1_last     <= dcmd.last;
        s1_src_hist <= dcmd.src_hist;
        s1_zero     <= dcmd.zero_tap;
        s1_out_last <= dcmd.out_last;
        s1_vaddr    <= v_addr;
        s1_weight   <= weight;
        prod_reg    <= opa * opb;
        s2_interp   <= s1_interp;
        s2_first    <= s1_first;
        s2_last     <= s1_last;
        s2_out_last <= s1_out_last;
        s2_vaddr    <= s1_vaddr;
        acc_reg     <= acc_next;
        s3_interp   <= s2_interp;
        s3_out_last <= s2_out_last;
        s3_vaddr    <= s2_vaddr;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (done_reg && s3_interp)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_reg && s3_interp)
        begin
            out_data_reg <= result;
            out_last_reg <= s3_out_last;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= dcmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            done_reg      <= s2_valid_reg && s2_last;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.busy     = s1_valid_reg || s2_valid_reg || done_reg;
    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign sample_out    = out_data_reg;
    assign last          = out_last_reg;

endmodule

// File: rtl/core/polyphase_linear_resampler.sv
// polyphase_linear_resampler: top level, step register and the two cores
// depends on plr_pkg, plr_ctrl and plr_datapath
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_stall  | cmd, sample_in, tap_index, tap_value
//   output  | out_valid / out_stall| sample_out, last
//   config  | cfg_valid / cfg_ready| step
//
// a tap write leaves the controller idle; a sample runs the branch sums of all NUM_PHASES
// phases on the one shared multiply-accumulate, then an interpolation for each output it
// causes
// after reset a clearing pass zeroes the tap store and history line; input stalls then
// a stalled output holds its result; the next sample is taken meanwhile but its
// outputs wait for the output register
module polyphase_linear_resampler
    import plr_pkg::*;
#(
    parameter int NUM_PHASES   = 8,
    parameter int NUM_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [TAP_IDX_W-1:0]           tap_index,
    input  logic signed [TAP_W-1:0]        tap_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [STEP_W-1:0]              step
);

    localparam int PL  = (NUM_TAPS + NUM_PHASES - 1) / NUM_PHASES;
    localparam int TW  = $clog2(NUM_TAPS);
    localparam int HLD = (PL > 1) ? PL - 1 : 1;
    localparam int HW  = (HLD > 1) ? $clog2(HLD) : 1;
    localparam int VW  = $clog2(NUM_PHASES + 1);

    logic [STEP_W-1:0]   step_reg;
    dp_cmd_t             dcmd;
    dp_stat_t            stat;
    logic [TW-1:0]       tap_addr;
    logic [HW-1:0]       hist_addr;
    logic [VW-1:0]       v_addr;
    logic [TW-1:0]       clr_addr;
    logic [WEIGHT_W-1:0] weight;

    // step register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_W'(ONE_Q16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            step_reg <= step;
        end
    end

    plr_ctrl #(
        .NUM_PHASES (NUM_PHASES),
        .NUM_TAPS   (NUM_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_cmd    (cmd),
        .step_q    (step_reg),
        .stat      (stat),
        .dcmd      (dcmd),
        .tap_addr  (tap_addr),
        .hist_addr (hist_addr),
        .v_addr    (v_addr),
        .clr_addr  (clr_addr),
        .weight    (weight)
    );

    plr_datapath #(
        .NUM_PHASES   (NUM_PHASES),
        .NUM_TAPS     (NUM_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dcmd       (dcmd),
        .tap_addr   (tap_addr),
        .hist_addr  (hist_addr),
        .v_addr     (v_addr),
        .clr_addr   (clr_addr),
        .weight     (weight),
        .sample_in  (sample_in),
        .tap_index  (tap_index),
        .tap_value  (tap_value),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .last       (last)
    );

endmodule

// File: rtl/core/plr_checker.sv
// plr_checker: port-level assertions for the resampler, bound to the top level
// depends on plr_pkg and polyphase_linear_resampler
module plr_checker
    import plr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    cmd,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [SAMPLE_WIDTH-1:0] sample_out,
    input logic                    last,
    input logic                    cfg_valid,
    input logic                    cfg_ready
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(last))
        else $error("output changed while stalled");

    // clearing pass blocks input right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input taken during clearing pass");

    // a sample transaction starts work, so input stalls next cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_SAMPLE) |=> in_stall)
        else $error("second sample taken while first in progress");

    // step register is always writable
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind polyphase_linear_resampler plr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_plr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);

// File: sim/polyphase_linear_resampler_test.sv
`timescale 1ns / 100ps
// polyphase_linear_resampler_test: self-checking testbench of the polyphase linear resampler
// depends on plr_pkg and polyphase_linear_resampler; predicts each output sample and compares
module polyphase_linear_resampler_test;
    import plr_pkg::*;

    localparam int PHASES    = 8;
    localparam int TAPS      = 64;
    localparam int SW        = 16;
    localparam int ROW_LEN   = (TAPS + PHASES - 1) / PHASES;
    localparam int IDLE_LIMIT = 20000;
    localparam longint SMAX  = 32767;
    localparam longint SMIN  = -32768;

    typedef struct {
        in_cmd_t           op;
        logic signed [15:0] smp;
        logic [5:0]        idx;
        logic signed [15:0] coef;
    } stim_t;

    typedef struct {
        logic signed [15:0] y;
        logic               fin;
    } outp_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic cmd;
    logic signed [SW-1:0] sample_in;
    logic [TAP_IDX_W-1:0] tap_index;
    logic signed [TAP_W-1:0] tap_value;
    logic out_valid;
    logic out_stall;
    logic signed [SW-1:0] sample_out;
    logic last;
    logic cfg_valid;
    logic cfg_ready;
    logic [STEP_W-1:0] step;

    // predictor state
    longint coef_mem[TAPS];
    longint hist_mem[ROW_LEN];
    longint prev_top;
    longint phase_acc;
    longint step_reg;

    stim_t pending_q[$];
    outp_t expected_q[$];
    int    errors;
    int    idle_cycles;
    bit    hold_off;
    int    burst_left;
    int    gap_left;
    bit    pause_tx;

    polyphase_linear_resampler #(
        .NUM_PHASES(PHASES),
        .NUM_TAPS(TAPS),
        .SAMPLE_WIDTH(SW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .sample_in(sample_in),
        .tap_index(tap_index),
        .tap_value(tap_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .step(step)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > SMAX)
            return SMAX;
        if (v < SMIN)
            return SMIN;
        return v;
    endfunction

    // work out the output samples caused by one transaction
    task automatic resample_item(stim_t it);
        longint br[PHASES + 1];
        longint acc, p, mu, y, st;
        int     k, n, t;
        outp_t  o;
        if (it.op == CMD_TAP)
        begin
            coef_mem[it.idx] = it.coef;
            return;
        end
        br[0] = prev_top;
        for (int j = 0; j < PHASES; j++)
        begin
            acc = coef_mem[j] * longint'(it.smp);
            for (int i = 1; i < ROW_LEN; i++)
            begin
                t = i * PHASES + j;
                if (t < TAPS)
                    acc += coef_mem[t] * hist_mem[i - 1];
            end
            br[j + 1] = clip16(floor_div(acc + 16384, 15));
        end
        for (int i = ROW_LEN - 2; i > 0; i--)
            hist_mem[i] = hist_mem[i - 1];
        hist_mem[0] = it.smp;
        st = (step_reg < ONE_Q16) ? ONE_Q16 : step_reg;
        p = phase_acc + ONE_Q16;
        n = 0;
        while (p < PHASES * ONE_Q16 && n < PHASES)
        begin
            k = int'(p >>> 16);
            mu = p & 16'hFFFF;
            y = clip16(floor_div(br[k] * (ONE_Q16 - mu) + br[k + 1] * mu + 32768, 16));
            o.y = y[15:0];
            o.fin = 1'b0;
            expected_q.push_back(o);
            n++;
            p += st;
        end
        if (n > 0)
            expected_q[$].fin = 1'b1;
        phase_acc = p - (PHASES + 1) * ONE_Q16;
        prev_top = br[PHASES];
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic stim_t rand_sample(bit extreme);
        stim_t s;
        s.op = CMD_SAMPLE;
        s.idx = 6'($urandom);
        s.coef = 16'($urandom);
        if (extreme)
            s.smp = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        else
            s.smp = 16'($urandom);
        return s;
    endfunction

    function automatic stim_t tap_item(int i, logic signed [15:0] c);
        stim_t s;
        s.op = CMD_TAP;
        s.smp = 16'($urandom);
        s.idx = 6'(i);
        s.coef = c;
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_step(longint v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        step <= STEP_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_reg = v;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                resample_item(pending_q.pop_front());
            end
            if (in_valid && in_stall)
            begin
                // payload held
            end
            else if (pending_q.size() != 0 && !pause_tx && gap_left == 0)
            begin
                in_valid <= 1'b1;
                cmd <= pending_q[0].op;
                sample_in <= pending_q[0].smp;
                tap_index <= pending_q[0].idx;
                tap_value <= pending_q[0].coef;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 30);
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // output monitor and stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("unexpected output", sample_out, 0);
                end
                else
                begin
                    if (sample_out !== expected_q[0].y)
                        report_mismatch("sample_out", sample_out, expected_q[0].y);
                    if (last !== expected_q[0].fin)
                        report_mismatch("last", last, expected_q[0].fin);
                    void'(expected_q.pop_front());
                end
            end
            if (hold_off)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog on stalled progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // long receiver hold-off, counted in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1'b1;
        repeat (2500) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        stim_t s;
        longint steps[6];
        errors = 0;
        idle_cycles = 0;
        pause_tx = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_SAMPLE;
        sample_in = '0;
        tap_index = '0;
        tap_value = '0;
        cfg_valid = 1'b0;
        step = '0;
        for (int i = 0; i < TAPS; i++)
            coef_mem[i] = 0;
        for (int i = 0; i < ROW_LEN; i++)
            hist_mem[i] = 0;
        prev_top = 0;
        phase_acc = 0;
        step_reg = ONE_Q16;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: samples through zero taps, tap extremes, saturating samples, then 0, -1 and +1
        pending_q.push_back(rand_sample(1'b1));
        pending_q.push_back(tap_item(0, 16'sh7FFF));
        pending_q.push_back(tap_item(63, 16'sh8000));
        pending_q.push_back(tap_item(8, 16'sh7FFF));
        pending_q.push_back(tap_item(7, 16'sh8000));
        pending_q.push_back(tap_item(1, 16'sh4000));
        for (int i = 0; i < 8; i++)
            pending_q.push_back(rand_sample(1'b1));
        s = rand_sample(1'b0);
        s.smp = 16'sh0000;
        pending_q.push_back(s);
        s.smp = 16'shFFFF;
        pending_q.push_back(s);
        s.smp = 16'sh0001;
        pending_q.push_back(s);
        wait_drained();

        // random phases over several step settings
        steps[0] = 65536;
        steps[1] = 4194303;
        steps[2] = 65536 + 12345;
        steps[3] = 3 * 65536 + 777;
        steps[4] = 32767 + 65536 * 9;
        steps[5] = $urandom_range(65536, 4194303);
        for (int ph = 0; ph < 6; ph++)
        begin
            write_step(steps[ph]);
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    pending_q.push_back(tap_item($urandom_range(0, 63), 16'($urandom)));
                else
                    pending_q.push_back(rand_sample($urandom_range(0, 9) == 0));
            end
            if (ph == 2)
            begin
                // sender waits mid-stream for every expected output
                while (pending_q.size() > 25)
                    @(posedge clk);
                pause_tx = 1'b1;
                while (expected_q.size() != 0)
                    @(posedge clk);
                pause_tx = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
